FILE: rtl/core/dtcp_pkg.sv
// ----------------------------------------------------------------------------
// dtcp_pkg
// Shared constants, status codes and controller/datapath structs for the
// duplicate filter table.
// ----------------------------------------------------------------------------
package dtcp_pkg;

  localparam int TABLE_CAPACITY = 4096;
  localparam int ADDR_W  = $clog2(TABLE_CAPACITY);
  localparam int HELD_W  = $clog2(TABLE_CAPACITY + 1);
  localparam int KEY_W   = 64;
  localparam int CNT_W   = 4;
  localparam int OCC_W   = 13;
  localparam int LIMIT_W = 13;
  localparam int PAR_W   = 32;
  localparam int DIST_W  = 8;
  localparam int STAT_W  = 3;
  localparam int CFG_W   = 13;

  localparam logic [CNT_W-1:0] COUNT_MAX = 4'd15;

  localparam logic [STAT_W-1:0] ST_NEW      = 3'd0;
  localparam logic [STAT_W-1:0] ST_DUP      = 3'd1;
  localparam logic [STAT_W-1:0] ST_DROP     = 3'd2;
  localparam logic [STAT_W-1:0] ST_NO_PRUNE = 3'd3;
  localparam logic [STAT_W-1:0] ST_PRUNED   = 3'd4;

  localparam logic REG_PRUNE_LIMIT = 1'b0;
  localparam logic REG_KEEP_MIN    = 1'b1;

  // controller commands to the datapath
  typedef struct packed {
    logic              load;
    logic              rd;
    logic              idx_inc;
    logic              hit_wr;
    logic              new_wr;
    logic              pr_wr;
    logic              held_load;
    logic              respond;
    logic [STAT_W-1:0] code;
  } dtcp_cmd_t;

  // datapath status to the controller
  typedef struct packed {
    logic mode;
    logic held_zero;
    logic over_limit;
    logic full;
    logic match;
    logic last;
    logic keep;
  } dtcp_stat_t;

endpackage

FILE: rtl/core/dtcp_ctrl.sv
// ----------------------------------------------------------------------------
// dtcp_ctrl
// Sequencer for lookup, insert and prune sweeps over the key table.
// ----------------------------------------------------------------------------
module dtcp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  dtcp_pkg::dtcp_stat_t st,
  output dtcp_pkg::dtcp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_DISP, S_SCAN_RD, S_SCAN_CMP, S_PR_RD, S_PR_CMP
  } state_t;

  state_t state, state_next;

  assign busy = (state != S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.code   = dtcp_pkg::ST_NEW;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        if (st.mode) begin
          if (st.over_limit) begin
            state_next = S_PR_RD;
          end else begin
            cmd.respond = 1'b1;
            cmd.code    = dtcp_pkg::ST_NO_PRUNE;
            state_next  = S_IDLE;
          end
        end else if (st.held_zero) begin
          cmd.new_wr  = 1'b1;
          cmd.respond = 1'b1;
          cmd.code    = dtcp_pkg::ST_NEW;
          state_next  = S_IDLE;
        end else begin
          state_next = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        priority if (st.match) begin
          cmd.hit_wr  = 1'b1;
          cmd.respond = 1'b1;
          cmd.code    = dtcp_pkg::ST_DUP;
          state_next  = S_IDLE;
        end else if (st.last) begin
          cmd.respond = 1'b1;
          if (st.full) begin
            cmd.code = dtcp_pkg::ST_DROP;
          end else begin
            cmd.new_wr = 1'b1;
            cmd.code   = dtcp_pkg::ST_NEW;
          end
          state_next = S_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_SCAN_RD;
        end
      end
      S_PR_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_PR_CMP;
      end
      S_PR_CMP: begin
        cmd.pr_wr = st.keep;
        if (st.last) begin
          cmd.held_load = 1'b1;
          cmd.respond   = 1'b1;
          cmd.code      = dtcp_pkg::ST_PRUNED;
          state_next    = S_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_PR_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/core/dtcp_datapath.sv
// ----------------------------------------------------------------------------
// dtcp_datapath
// Compact key/count table, fill count, sweep pointers, config and result
// registers.
// ----------------------------------------------------------------------------
module dtcp_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  dtcp_pkg::dtcp_cmd_t                 cmd,
  output dtcp_pkg::dtcp_stat_t                st,
  input  logic                                mode,
  input  logic [dtcp_pkg::KEY_W-1:0]          state_key,
  input  logic [dtcp_pkg::PAR_W-1:0]          parent_index,
  input  logic signed [dtcp_pkg::DIST_W-1:0]  step_dist,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [dtcp_pkg::CFG_W-1:0]          cfg_data,
  output logic                                done,
  output logic [dtcp_pkg::STAT_W-1:0]         status,
  output logic [dtcp_pkg::PAR_W-1:0]          out_parent,
  output logic signed [dtcp_pkg::DIST_W-1:0]  out_dist,
  output logic [dtcp_pkg::OCC_W-1:0]          occupancy
);

  localparam int ENT_W = dtcp_pkg::KEY_W + dtcp_pkg::CNT_W;

  logic [ENT_W-1:0] mem [dtcp_pkg::TABLE_CAPACITY];
  logic [ENT_W-1:0] rdata;
  logic [ENT_W-1:0] wdata;
  logic [dtcp_pkg::ADDR_W-1:0] waddr;
  logic we;

  logic [dtcp_pkg::HELD_W-1:0] held, held_next;
  logic [dtcp_pkg::HELD_W-1:0] idx, wptr;
  logic mode_r;
  logic [dtcp_pkg::KEY_W-1:0] key_r;
  logic [dtcp_pkg::PAR_W-1:0] par_r;
  logic signed [dtcp_pkg::DIST_W-1:0] dist_r;
  logic [dtcp_pkg::LIMIT_W-1:0] prune_limit;
  logic [dtcp_pkg::CNT_W-1:0] keep_min_count;

  logic [dtcp_pkg::KEY_W-1:0] rkey;
  logic [dtcp_pkg::CNT_W-1:0] rcnt, rcnt_inc;

  assign rkey = rdata[ENT_W-1:dtcp_pkg::CNT_W];
  assign rcnt = rdata[dtcp_pkg::CNT_W-1:0];
  assign rcnt_inc = (rcnt == dtcp_pkg::COUNT_MAX) ? rcnt : rcnt + 1'b1;

  // status to the controller
  always_comb begin
    st.mode       = mode_r;
    st.held_zero  = (held == '0);
    st.over_limit = (32'(held) > 32'(prune_limit));
    st.full       = (32'(held) >= 32'(dtcp_pkg::TABLE_CAPACITY));
    st.match      = (rkey == key_r);
    st.last       = ((idx + 1'b1) == held);
    st.keep       = (rcnt >= keep_min_count);
  end

  // table write port select
  always_comb begin
    we    = cmd.hit_wr | cmd.new_wr | cmd.pr_wr;
    waddr = idx[dtcp_pkg::ADDR_W-1:0];
    wdata = {key_r, rcnt_inc};
    priority if (cmd.new_wr) begin
      waddr = held[dtcp_pkg::ADDR_W-1:0];
      wdata = {key_r, dtcp_pkg::CNT_W'(1)};
    end else if (cmd.pr_wr) begin
      waddr = wptr[dtcp_pkg::ADDR_W-1:0];
      wdata = {rkey, dtcp_pkg::CNT_W'(0)};
    end else begin
      waddr = idx[dtcp_pkg::ADDR_W-1:0];
      wdata = {key_r, rcnt_inc};
    end
  end

  // table memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd) begin
      rdata <= mem[idx[dtcp_pkg::ADDR_W-1:0]];
    end
  end

  // fill count after this cycle
  always_comb begin
    priority if (cmd.new_wr) begin
      held_next = held + 1'b1;
    end else if (cmd.held_load) begin
      held_next = wptr + dtcp_pkg::HELD_W'(cmd.pr_wr);
    end else begin
      held_next = held;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      held           <= '0;
      idx            <= '0;
      wptr           <= '0;
      done           <= 1'b0;
      prune_limit    <= dtcp_pkg::LIMIT_W'(3072);
      keep_min_count <= dtcp_pkg::CNT_W'(4);
    end else begin
      held <= held_next;
      done <= cmd.respond;
      if (cmd.load) begin
        idx  <= '0;
        wptr <= '0;
      end else begin
        if (cmd.idx_inc) idx <= idx + 1'b1;
        if (cmd.pr_wr) wptr <= wptr + 1'b1;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          dtcp_pkg::REG_PRUNE_LIMIT: prune_limit <= cfg_data[dtcp_pkg::LIMIT_W-1:0];
          dtcp_pkg::REG_KEEP_MIN:    keep_min_count <= cfg_data[dtcp_pkg::CNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= mode;
      key_r  <= state_key;
      par_r  <= parent_index;
      dist_r <= step_dist;
    end
    if (cmd.respond) begin
      status    <= cmd.code;
      occupancy <= dtcp_pkg::OCC_W'(held_next);
      if (cmd.code == dtcp_pkg::ST_NEW) begin
        out_parent <= par_r;
        out_dist   <= dist_r;
      end else begin
        out_parent <= '0;
        out_dist   <= '0;
      end
    end
  end

  a_held_cap: assert property (@(posedge clk) disable iff (rst)
    32'(held) <= 32'(dtcp_pkg::TABLE_CAPACITY))
    else $error("fill count above capacity");
  a_wptr_le_idx: assert property (@(posedge clk) disable iff (rst)
    wptr <= idx + 1'b1)
    else $error("prune write pointer ahead of read pointer");
  a_new_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.new_wr |=> held == $past(held) + 1'b1)
    else $error("insert did not grow fill count");
  a_payload_zero: assert property (@(posedge clk) disable iff (rst)
    done && status != dtcp_pkg::ST_NEW |-> out_parent == '0 && out_dist == '0)
    else $error("payload on non-new result");

endmodule

FILE: rtl/core/dedup_table_count_prune.sv
// ----------------------------------------------------------------------------
// dedup_table_count_prune
// On start the item is loaded; an offer then probes the held keys in order,
//   one memory read per probe, until a match or the last key, and inserts at
//   once into an empty table. A batch end reads every held key when pruning.
// Start is taken only while idle, so a new item waits for the last result;
//   the receiver cannot stall, done is a one-cycle strobe.
// Synchronous reset empties the table (fill count zero) and loads the limits.
// ----------------------------------------------------------------------------
module dedup_table_count_prune (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                mode,
  input  logic [dtcp_pkg::KEY_W-1:0]          state_key,
  input  logic [dtcp_pkg::PAR_W-1:0]          parent_index,
  input  logic signed [dtcp_pkg::DIST_W-1:0]  step_dist,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [dtcp_pkg::CFG_W-1:0]          cfg_data,
  output logic                                done,
  output logic [dtcp_pkg::STAT_W-1:0]         status,
  output logic [dtcp_pkg::PAR_W-1:0]          out_parent,
  output logic signed [dtcp_pkg::DIST_W-1:0]  out_dist,
  output logic [dtcp_pkg::OCC_W-1:0]          occupancy
);

  dtcp_pkg::dtcp_cmd_t  cmd;
  dtcp_pkg::dtcp_stat_t st;

  // sequencer
  dtcp_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .st   (st),
    .cmd  (cmd)
  );

  // table and result path
  dtcp_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .mode        (mode),
    .state_key   (state_key),
    .parent_index(parent_index),
    .step_dist   (step_dist),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .done        (done),
    .status      (status),
    .out_parent  (out_parent),
    .out_dist    (out_dist),
    .occupancy   (occupancy)
  );

endmodule

FILE: test/dedup_table_count_prune_test.sv
// ----------------------------------------------------------------------------
// dedup_table_count_prune_test
// Self-checking bench for the duplicate filter table: items go in through the
// start/busy command port, and each result strobed on done is checked field by
// field against a table model kept in the bench. The run covers payload
// extremes, count saturation, pruning at several limits and keep thresholds,
// a large table filled back to back, and random batches of keys drawn from
// small pools.
// ----------------------------------------------------------------------------
module dedup_table_count_prune_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic MODE_OFFER = 1'b0;
  localparam logic MODE_BATCH = 1'b1;

  typedef struct packed {
    logic [dtcp_pkg::STAT_W-1:0]        status;
    logic [dtcp_pkg::PAR_W-1:0]         parent;
    logic signed [dtcp_pkg::DIST_W-1:0] distance;
    logic [dtcp_pkg::OCC_W-1:0]         occupancy;
  } filter_result_t;

  logic                               clk;
  logic                               rst;
  logic                               start;
  logic                               busy;
  logic                               mode;
  logic [dtcp_pkg::KEY_W-1:0]         state_key;
  logic [dtcp_pkg::PAR_W-1:0]         parent_index;
  logic signed [dtcp_pkg::DIST_W-1:0] step_dist;
  logic                               cfg_we;
  logic                               cfg_index;
  logic [dtcp_pkg::CFG_W-1:0]         cfg_data;
  logic                               done;
  logic [dtcp_pkg::STAT_W-1:0]        status;
  logic [dtcp_pkg::PAR_W-1:0]         out_parent;
  logic signed [dtcp_pkg::DIST_W-1:0] out_dist;
  logic [dtcp_pkg::OCC_W-1:0]         occupancy;

  dedup_table_count_prune uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode),
    .state_key(state_key), .parent_index(parent_index), .step_dist(step_dist),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .status(status), .out_parent(out_parent), .out_dist(out_dist),
    .occupancy(occupancy)
  );

  // table model
  logic [dtcp_pkg::KEY_W-1:0]   model_key [dtcp_pkg::TABLE_CAPACITY];
  logic [dtcp_pkg::CNT_W-1:0]   model_count [dtcp_pkg::TABLE_CAPACITY];
  logic                         model_valid [dtcp_pkg::TABLE_CAPACITY];
  int unsigned                  model_held;
  logic [dtcp_pkg::LIMIT_W-1:0] model_limit;
  logic [dtcp_pkg::CNT_W-1:0]   model_keep;

  filter_result_t pending_results[$];
  int  error_count;
  int  results_seen;
  int  new_seen, dup_seen, drop_seen, prune_seen, noprune_seen;
  bit  no_gaps;

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic filter_result_t filter_predict(
      input logic m, input logic [dtcp_pkg::KEY_W-1:0] k,
      input logic [dtcp_pkg::PAR_W-1:0] p,
      input logic signed [dtcp_pkg::DIST_W-1:0] d);
    filter_result_t r;
    int hit_slot;
    int free_slot;
    int unsigned kept;
    r = '0;
    if (m == MODE_BATCH) begin
      if (model_held > model_limit) begin
        kept = 0;
        for (int i = 0; i < dtcp_pkg::TABLE_CAPACITY; i++) begin
          if (model_valid[i]) begin
            if (model_count[i] >= model_keep) begin
              model_count[i] = '0;
              kept++;
            end else begin
              model_valid[i] = 1'b0;
            end
          end
        end
        model_held = kept;
        r.status = dtcp_pkg::ST_PRUNED;
      end else begin
        r.status = dtcp_pkg::ST_NO_PRUNE;
      end
    end else begin
      hit_slot = -1;
      free_slot = -1;
      for (int i = 0; i < dtcp_pkg::TABLE_CAPACITY; i++) begin
        if (model_valid[i] && model_key[i] == k && hit_slot < 0) hit_slot = i;
        if (!model_valid[i] && free_slot < 0) free_slot = i;
      end
      if (hit_slot >= 0) begin
        if (model_count[hit_slot] != dtcp_pkg::COUNT_MAX) model_count[hit_slot]++;
        r.status = dtcp_pkg::ST_DUP;
      end else if (free_slot < 0) begin
        r.status = dtcp_pkg::ST_DROP;
      end else begin
        model_key[free_slot] = k;
        model_count[free_slot] = 4'd1;
        model_valid[free_slot] = 1'b1;
        model_held++;
        r.status = dtcp_pkg::ST_NEW;
        r.parent = p;
        r.distance = d;
      end
    end
    r.occupancy = model_held[dtcp_pkg::OCC_W-1:0];
    return r;
  endfunction

  // one item transfer, then the sender's gap
  task automatic send_item(input logic m, input logic [dtcp_pkg::KEY_W-1:0] k,
                           input logic [dtcp_pkg::PAR_W-1:0] p,
                           input logic signed [dtcp_pkg::DIST_W-1:0] d);
    int gap;
    filter_result_t exp_r;
    start <= 1'b1;
    mode <= m;
    state_key <= k;
    parent_index <= p;
    step_dist <= d;
    do @(posedge clk); while (busy);
    exp_r = filter_predict(m, k, p, d);
    pending_results = {pending_results, exp_r};
    @(negedge clk);
    gap = no_gaps ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic offer_random_key(input logic [dtcp_pkg::KEY_W-1:0] k);
    send_item(MODE_OFFER, k, dtcp_pkg::PAR_W'($urandom), dtcp_pkg::DIST_W'($urandom));
  endtask

  task automatic end_batch();
    send_item(MODE_BATCH, {$urandom, $urandom}, dtcp_pkg::PAR_W'($urandom),
              dtcp_pkg::DIST_W'($urandom));
  endtask

  // hold the sender until all results are in and the block is settled
  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [dtcp_pkg::CFG_W-1:0] value);
    drain_results();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == dtcp_pkg::REG_PRUNE_LIMIT) model_limit = value[dtcp_pkg::LIMIT_W-1:0];
    else model_keep = value[dtcp_pkg::CNT_W-1:0];
  endtask

  // result check against the oldest expectation
  always @(posedge clk) begin
    filter_result_t exp_r;
    if (!rst && done) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d occupancy=%0d", $time, status, occupancy);
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        case (exp_r.status)
          dtcp_pkg::ST_NEW: new_seen++;
          dtcp_pkg::ST_DUP: dup_seen++;
          dtcp_pkg::ST_DROP: drop_seen++;
          dtcp_pkg::ST_PRUNED: prune_seen++;
          default: noprune_seen++;
        endcase
        if (status !== exp_r.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status, status);
          error_count++;
        end
        if (out_parent !== exp_r.parent) begin
          $display("%0t: out_parent expected %h actual %h", $time, exp_r.parent, out_parent);
          error_count++;
        end
        if (out_dist !== exp_r.distance) begin
          $display("%0t: out_dist expected %0d actual %0d", $time, exp_r.distance, out_dist);
          error_count++;
        end
        if (occupancy !== exp_r.occupancy) begin
          $display("%0t: occupancy expected %0d actual %0d", $time, exp_r.occupancy,
                   occupancy);
          error_count++;
        end
      end
    end
  end

  // payload extremes, duplicates and count saturation
  task automatic test_payload_extremes();
    send_item(MODE_OFFER, 64'h0, 32'h0, -8'sd128);
    send_item(MODE_OFFER, {dtcp_pkg::KEY_W{1'b1}}, 32'hFFFF_FFFF, 8'sd127);
    send_item(MODE_OFFER, 64'h0, 32'h1234_5678, 8'sd5);
    send_item(MODE_OFFER, 64'hA5A5_5A5A_F00D_0001, 32'hFFFF_FFFF, -8'sd1);
    for (int i = 0; i < 17; i++) offer_random_key({dtcp_pkg::KEY_W{1'b1}});
    end_batch();
  endtask

  // batch ends around the limit, zero limit and zero keep threshold
  task automatic test_prune_settings();
    write_reg(dtcp_pkg::REG_PRUNE_LIMIT, 13'd3);
    write_reg(dtcp_pkg::REG_KEEP_MIN, 13'd15);
    end_batch();
    offer_random_key(64'hDEAD_BEEF_0000_0003);
    end_batch();
    write_reg(dtcp_pkg::REG_PRUNE_LIMIT, 13'd0);
    write_reg(dtcp_pkg::REG_KEEP_MIN, 13'd0);
    end_batch();
    end_batch();
    write_reg(dtcp_pkg::REG_PRUNE_LIMIT, 13'h1FFF);
    end_batch();
  endtask

  // fill a large table back to back, then prune it
  task automatic test_large_table();
    write_reg(dtcp_pkg::REG_PRUNE_LIMIT, 13'd4096);
    write_reg(dtcp_pkg::REG_KEEP_MIN, 13'd2);
    no_gaps = 1'b1;
    for (int i = 0; i < 190; i++)
      offer_random_key({32'hC0DE_0000, i[31:0]});
    no_gaps = 1'b0;
    offer_random_key(64'hFFFF_0000_FFFF_0000);
    offer_random_key(64'h0123_4567_89AB_CDEF);
    offer_random_key({32'hC0DE_0000, 32'd7});
    end_batch();
    write_reg(dtcp_pkg::REG_PRUNE_LIMIT, 13'd100);
    end_batch();
  endtask

  // random batches over small key pools, several limit settings
  task automatic test_random_batches();
    logic [dtcp_pkg::KEY_W-1:0] key_pool [24];
    int roll;
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(dtcp_pkg::REG_PRUNE_LIMIT, ph == 0 ? 13'd1 : 13'($urandom_range(2, 40)));
      write_reg(dtcp_pkg::REG_KEEP_MIN,
                ph == 1 ? 13'd15 : (ph == 2 ? 13'd0 : 13'($urandom_range(0, 15))));
      foreach (key_pool[j]) key_pool[j] = {$urandom, $urandom};
      for (int n = 0; n < 205; n++) begin
        if (n % 40 == 0) no_gaps = ($urandom_range(0, 2) == 0);
        roll = $urandom_range(0, 99);
        if (roll < 12) end_batch();
        else if (roll < 27) offer_random_key({$urandom, $urandom});
        else offer_random_key(key_pool[$urandom_range(0, 23)]);
      end
      no_gaps = 1'b0;
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    mode = MODE_OFFER;
    state_key = '0;
    parent_index = '0;
    step_dist = '0;
    cfg_we = 1'b0;
    cfg_index = dtcp_pkg::REG_PRUNE_LIMIT;
    cfg_data = '0;
    error_count = 0;
    results_seen = 0;
    new_seen = 0;
    dup_seen = 0;
    drop_seen = 0;
    prune_seen = 0;
    noprune_seen = 0;
    no_gaps = 1'b0;
    for (int i = 0; i < dtcp_pkg::TABLE_CAPACITY; i++) begin
      model_valid[i] = 1'b0;
      model_key[i] = '0;
      model_count[i] = '0;
    end
    model_held = 0;
    model_limit = 13'd3072;
    model_keep = 4'd4;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_payload_extremes();
    test_prune_settings();
    test_large_table();
    test_random_batches();

    // end of stimulus
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("covered %0d results: %0d new, %0d duplicate, %0d dropped", results_seen,
             new_seen, dup_seen, drop_seen);
    $display("batch ends: %0d pruned, %0d left alone", prune_seen, noprune_seen);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(64'd1_000_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
